// ===== src/cobsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cobsd_pkg
// Shared types and constants of the COBS stream frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cobsd_pkg;

  localparam int unsigned CAP_W = 13;            // capacity and length width
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
  localparam logic [7:0] NO_STUFF_CODE = 8'hFF;  // code with no trailing zero
  localparam logic [7:0] DELIM = 8'h00;          // frame delimiter

  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_GOOD       = 2'd1,
    KIND_INCOMPLETE = 2'd2,
    KIND_OVERFLOW   = 2'd3
  } kind_t;

  // One decoder result, with its valid flag
  typedef struct packed {
    logic             vld;
    kind_t            kind;
    logic [7:0]       data;
    logic [CAP_W-1:0] len;
  } res_t;

endpackage

`default_nettype wire

// ===== src/cobsd_in_reg.sv =====
// ----------------------------------------------------------------------------
// cobsd_in_reg
// Input register: holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cobsd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,      // decode stage consumes the held byte
  output logic            hold_vld,
  output logic [7:0]      hold_byte
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !vld_r || take;
  assign hold_vld  = vld_r;
  assign hold_byte = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ===== src/cobsd_core.sv =====
// ----------------------------------------------------------------------------
// cobsd_core
// Frame state and combinational decode of one byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module cobsd_core
  import cobsd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,     // decode rx_byte this cycle
  input  wire logic [7:0]       rx_byte,
  input  wire logic [CAP_W-1:0] capacity,
  output res_t                  res
);

  // Count never exceeds min(capacity register, MAX_FRAME_BYTES)
  localparam int unsigned MAX_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CNT_W = (MAX_W < CAP_W) ? MAX_W : CAP_W;
  localparam int unsigned SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 2;

  logic             awaiting_r, awaiting_nxt;
  logic [7:0]       remaining_r, remaining_nxt;
  logic             last_ff_r, last_ff_nxt;   // last code was 0xff
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [CNT_W-1:0] cap_eff;
  logic [SUM_W-1:0] need;
  logic             stuff_zero;

  always_comb begin
    if (32'(capacity) > MAX_FRAME_BYTES) begin
      cap_eff = CNT_W'(MAX_FRAME_BYTES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign stuff_zero = !last_ff_r;
  assign need = SUM_W'(count_r) + SUM_W'(stuff_zero) + SUM_W'(rx_byte);

  always_comb begin
    awaiting_nxt  = awaiting_r;
    remaining_nxt = remaining_r;
    last_ff_nxt   = last_ff_r;
    count_nxt     = count_r;
    res           = '{vld: 1'b0, kind: KIND_BYTE, data: 8'd0, len: '0};

    if (step) begin
      if (rx_byte == DELIM) begin
        awaiting_nxt  = 1'b0;
        count_nxt     = '0;
        remaining_nxt = 8'd0;
        last_ff_nxt   = 1'b1;
        if (count_r != '0) begin
          res.vld = 1'b1;
          if (remaining_r == 8'd0) begin
            res.kind = KIND_GOOD;
            res.len  = CAP_W'(count_r);
          end else begin
            res.kind = KIND_INCOMPLETE;
          end
        end
      end else if (awaiting_r) begin
        // discard until a delimiter
      end else if (remaining_r != 8'd0) begin
        remaining_nxt = remaining_r - 8'd1;
        count_nxt     = count_r + CNT_W'(1);
        res.vld       = 1'b1;
        res.data      = rx_byte;
      end else begin
        // code byte opens a block
        last_ff_nxt   = (rx_byte == NO_STUFF_CODE);
        remaining_nxt = rx_byte - 8'd1;
        if (need > SUM_W'(cap_eff)) begin
          count_nxt    = '0;
          awaiting_nxt = 1'b1;
          res.vld      = 1'b1;
          res.kind     = KIND_OVERFLOW;
        end else if (stuff_zero) begin
          count_nxt = count_r + CNT_W'(1);
          res.vld   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b1;
      remaining_r <= 8'd0;
      last_ff_r   <= 1'b0;
      count_r     <= '0;
    end else begin
      awaiting_r  <= awaiting_nxt;
      remaining_r <= remaining_nxt;
      last_ff_r   <= last_ff_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/cobs_stream_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// cobs_stream_frame_decoder_unit
// Decodes a zero-delimited COBS byte stream into provisional data bytes and
// per-frame status requests (good with length, incomplete, overflow).
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | in_byte[7:0] raw received byte
//  out     | out_valid / out_ready | out_kind[1:0], out_byte[7:0],
//          |                       | out_frame_length[12:0]
//  cfg     | cfg_valid / cfg_ready | cfg_frame_capacity[12:0]
//
//  One byte a cycle while out is not stalled: input register -> decode -> result
//  register; a result is offered on out once its byte has passed both registers.
//  The decode stage moves on whenever the result register is empty or being
//  emptied, so a stalled consumer holds back the input only after the input
//  register fills. Bytes that yield no request are consumed and load no result.
//  Synchronous active-low reset: decoder waits for a delimiter, capacity 4096.
//  cfg_ready is always high; capacity is meant to be changed when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cobs_stream_frame_decoder_unit
  import cobsd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // received stream
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  // decoded requests
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte,
  output logic [CAP_W-1:0]      out_frame_length,
  // capacity register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_frame_capacity
);

  logic             hold_vld;
  logic [7:0]       hold_byte;
  logic             take;
  res_t             res;

  logic [CAP_W-1:0] capacity_r;
  logic             out_vld_r, out_vld_nxt;
  res_t             out_r;

  assign cfg_ready = 1'b1;

  // Decode proceeds when the result register has room this cycle
  assign take = hold_vld && (!out_vld_r || out_ready);

  cobsd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .take      (take),
    .hold_vld  (hold_vld),
    .hold_byte (hold_byte)
  );

  cobsd_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (take),
    .rx_byte  (hold_byte),
    .capacity (capacity_r),
    .res      (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = res.vld;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      capacity_r <= CAP_RESET;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_frame_capacity;
      end
    end
    if (take && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_r.kind;
  assign out_byte         = out_r.data;
  assign out_frame_length = out_r.len;

endmodule

`default_nettype wire
